// ===== hdl/tlf_pkg.sv =====
// shared types and constants of the text line fold block
// no dependencies

package tlf_pkg;

    localparam int LINE_DEPTH_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // job fields are sized for the largest supported line store
    localparam int CNT_MAX_W = 11;
    localparam int IDX_MAX_W = 10;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_MODE = 2'd1;

    localparam logic [5:0] LINE_WIDTH_RST = 6'd63;
    localparam logic       BREAK_MODE_RST = 1'b1;

    localparam logic CMD_TEXT  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef struct packed {
        logic [CNT_MAX_W-1:0] rd_len;
        logic [IDX_MAX_W-1:0] rd_start;
        logic                 nl;
        logic                 chr;
        logic                 store;
        logic [IDX_MAX_W-1:0] wr_idx;
        logic [7:0]           ch;
    } t_job;

endpackage

// ===== hdl/tlf_queue.sv =====
// short job queue between the classifier and the emitter
// depends on tlf_pkg

module tlf_queue #(
    parameter int DEPTH = tlf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tlf_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output tlf_pkg::t_job o_data,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = $clog2(DEPTH + 1);

    tlf_pkg::t_job  r_slot [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [QW-1:0]  r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full  = (r_count == QW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== hdl/tlf_front.sv =====
// input classifier: config registers, line bookkeeping, job generation
// depends on tlf_pkg

module tlf_front #(
    parameter int LINE_DEPTH = tlf_pkg::LINE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tlf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [5:0]                    i_cfg_data,
    input  logic                          i_full,
    output logic                          o_push,
    output tlf_pkg::t_job                 o_job
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int KW = (CW > 6) ? CW : 6;

    logic [5:0]    r_width;
    logic          r_mode;
    logic [AW-1:0] r_head,  n_head;
    logic [KW-1:0] r_count, n_count;
    logic [AW-1:0] r_boff,  n_boff;
    logic          r_blank, n_blank;

    logic          accept;
    logic          cfg_hit;
    logic [KW-1:0] w_hard;
    logic [KW-1:0] w_word;
    logic          wrap;
    logic          keep_blank;
    logic [KW-1:0] emit_n;
    logic [AW-1:0] head_a;
    logic [KW-1:0] count_a;
    logic          is_blank;
    tlf_pkg::t_job job;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [KW-1:0] b);
        logic [KW:0] s;
        s = {{(KW + 1 - AW){1'b0}}, a} + {1'b0, b};
        if (s >= (KW + 1)'(LINE_DEPTH)) begin
            s = s - (KW + 1)'(LINE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign o_s_tready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && !i_full;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == tlf_pkg::REG_LINE_WIDTH ||
                                         i_cfg_index == tlf_pkg::REG_BREAK_MODE);

    assign w_hard = (r_width == '0) ? KW'(1) : KW'(r_width);
    assign w_word = (w_hard > KW'(LINE_DEPTH)) ? KW'(LINE_DEPTH) : w_hard;

    // word mode overflow split
    assign wrap       = (r_count >= w_word);
    assign keep_blank = r_blank && (KW'(r_boff) < r_count);
    assign emit_n     = !wrap ? '0 : (keep_blank ? KW'(r_boff) + 1'b1 : r_count);
    assign head_a     = ring_add(r_head, emit_n);
    assign count_a    = r_count - emit_n;
    assign is_blank   = (i_s_tdata == tlf_pkg::CH_SP) || (i_s_tdata == tlf_pkg::CH_TAB);

    always_comb begin
        job          = '0;
        job.rd_start = tlf_pkg::IDX_MAX_W'(r_head);
        job.ch       = i_s_tdata;
        n_head       = r_head;
        n_count      = r_count;
        n_boff       = r_boff;
        n_blank      = r_blank;
        if (!r_mode) begin
            if (i_s_tuser == tlf_pkg::CMD_FLUSH) begin
                n_count = '0;
            end else if (i_s_tdata == tlf_pkg::CH_NL) begin
                job.chr = 1'b1;
                n_count = '0;
            end else begin
                job.nl  = (r_count >= w_hard);
                job.chr = 1'b1;
                n_count = (job.nl ? '0 : r_count) + 1'b1;
            end
        end else begin
            if (i_s_tuser == tlf_pkg::CMD_FLUSH || i_s_tdata == tlf_pkg::CH_NL) begin
                job.rd_len = tlf_pkg::CNT_MAX_W'(r_count);
                job.nl     = (i_s_tuser == tlf_pkg::CMD_TEXT);
                n_head     = '0;
                n_count    = '0;
                n_boff     = '0;
                n_blank    = 1'b0;
            end else begin
                job.rd_len = tlf_pkg::CNT_MAX_W'(emit_n);
                job.nl     = wrap;
                job.store  = 1'b1;
                job.wr_idx = tlf_pkg::IDX_MAX_W'(ring_add(head_a, count_a));
                n_head     = head_a;
                n_count    = count_a + 1'b1;
                n_blank    = is_blank || (r_blank && !wrap);
                n_boff     = is_blank ? count_a[AW-1:0] : (wrap ? '0 : r_boff);
            end
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.rd_len != '0 || job.nl || job.chr || job.store);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= tlf_pkg::LINE_WIDTH_RST;
            r_mode  <= tlf_pkg::BREAK_MODE_RST;
            r_head  <= '0;
            r_count <= '0;
            r_boff  <= '0;
            r_blank <= 1'b0;
        end else if (cfg_hit) begin
            if (i_cfg_index == tlf_pkg::REG_LINE_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_mode <= i_cfg_data[0];
            end
            r_head  <= '0;
            r_count <= '0;
            r_boff  <= '0;
            r_blank <= 1'b0;
        end else if (accept) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_boff  <= n_boff;
            r_blank <= n_blank;
        end
    end

endmodule

// ===== hdl/tlf_back.sv =====
// emitter: line store, job sequencing and output register
// depends on tlf_pkg

module tlf_back #(
    parameter int LINE_DEPTH = tlf_pkg::LINE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tlf_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_NL,
        S_CHR,
        S_WR
    } t_state;

    logic [7:0]    r_store [LINE_DEPTH];
    logic [7:0]    r_rd_data;

    t_state        r_state,   n_state;
    tlf_pkg::t_job r_job,     n_job;
    logic [CW-1:0] r_left,    n_left;
    logic [AW-1:0] r_rd_idx,  n_rd_idx;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_data,  n_out_data;
    logic          r_out_last,  n_out_last;
    logic          out_free;

    function automatic t_state after_buf(input tlf_pkg::t_job j);
        if (j.nl) begin
            return S_NL;
        end else if (j.chr) begin
            return S_CHR;
        end else if (j.store) begin
            return S_WR;
        end
        return S_IDLE;
    endfunction

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
        if (p == AW'(LINE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_store[r_job.wr_idx[AW-1:0]] <= r_job.ch;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_left      = r_left;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_job    = i_job;
                    n_left   = CW'(i_job.rd_len);
                    n_rd_idx = i_job.rd_start[AW-1:0];
                    n_state  = (i_job.rd_len != '0) ? S_READ : after_buf(i_job);
                end
            end
            S_READ: begin
                n_rd_idx = idx_inc(r_rd_idx);
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_data;
                    n_out_last  = (r_left == CW'(1)) && !r_job.nl && !r_job.chr;
                    n_left      = r_left - 1'b1;
                    n_state     = (r_left == CW'(1)) ? after_buf(r_job) : S_READ;
                end
            end
            S_NL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = tlf_pkg::CH_NL;
                    n_out_last  = !r_job.chr;
                    n_state     = r_job.chr ? S_CHR : (r_job.store ? S_WR : S_IDLE);
                end
            end
            S_CHR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_job.ch;
                    n_out_last  = 1'b1;
                    n_state     = r_job.store ? S_WR : S_IDLE;
                end
            end
            S_WR: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
        end
        r_job      <= n_job;
        r_rd_idx   <= n_rd_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_LOAD) |-> r_left != '0)
        else $error("buffered emit with nothing left");
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && !$past(r_state == S_LOAD)) |-> $past(r_state == S_READ))
        else $error("store data used without a read");
`endif

endmodule

// ===== hdl/text_line_fold_core.sv =====
// text line fold core: folds a byte stream into lines of bounded width
// depends on tlf_pkg, tlf_front, tlf_queue, tlf_back
// usage:
//   slave stream: i_s_tdata is the text byte, i_s_tuser the command (0 text,
//   1 flush of the pending line). master stream: o_m_tdata is the emitted
//   byte, o_m_tlast marks the last word caused by one input word.
//   config channel: index 0 line width (6 bits), index 1 break mode (bit 0,
//   1 breaks after the last blank). always ready; writes clear the line state
//   and the user must issue them only while the block is idle; the block
//   itself does not enforce this.
// sequencing:
//   an input word is classified in its accept cycle and queued as at most
//   one job. the emitter takes a new job only from its idle state, reads each
//   buffered byte back from the line store through a registered read port
//   (a read state, then a load state), then sends any inserted newline and
//   the passed-through byte, and for a stored byte last writes it to the
//   line store.
// reset: synchronous, active low; clears line state, width 63, break-at-blanks on
// stall: a stalled master side holds the output register; the job queue
//   keeps taking input words until it fills, then o_s_tready drops.

module text_line_fold_core #(
    parameter int LINE_DEPTH  = tlf_pkg::LINE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = tlf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // text_byte
    input  logic                          i_s_tuser,   // command
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // out_byte
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tlf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [5:0]                    i_cfg_data
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    tlf_pkg::t_job job_in;
    tlf_pkg::t_job job_out;

    tlf_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job_in)
    );

    tlf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    tlf_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
